// ===== sv/assert_macros.svh =====
// assertion helpers included by url_percent_decoder.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define UPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define UPD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/upd_pkg.sv =====
`timescale 1ns / 1ps

package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LC_A    = 8'h61;
	localparam logic [7:0] CH_LC_F    = 8'h66;
	localparam logic [7:0] CH_UC_A    = 8'h41;
	localparam logic [7:0] CH_UC_F    = 8'h46;
	localparam logic [4:0] HEX_NONE   = 5'd16;
	localparam logic [4:0] HEX_TEN    = 5'd10;

	localparam int UPD_QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		PH_PLAIN = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	// up to three output bytes caused by one request
	typedef struct packed {
		logic [1:0]      cnt;
		logic            last;
		logic [2:0][7:0] data;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// hex digit value, or 16 when not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = HEX_NONE;
		if (c >= CH_ZERO && c <= CH_NINE)
			v = 5'(c - CH_ZERO);
		else if (c >= CH_LC_A && c <= CH_LC_F)
			v = 5'(c - CH_LC_A) + HEX_TEN;
		else if (c >= CH_UC_A && c <= CH_UC_F)
			v = 5'(c - CH_UC_A) + HEX_TEN;
		return v;
	endfunction

endpackage

// ===== sv/upd_front.sv =====
`timescale 1ns / 1ps

module upd_front import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	output cmd_t       cmd
);

	phase_t     phase_q, phase_d;
	logic [7:0] held_q, held_d;
	logic [4:0] v;
	logic [4:0] hv;
	logic       do_plain;
	logic [1:0] n;

	always_comb begin
		v        = hex_value(in_byte);
		hv       = hex_value(held_q);
		cmd      = '0;
		phase_d  = PH_PLAIN;
		held_d   = '0;
		do_plain = 1'b0;
		n        = 2'd0;
		unique case (phase_q)
			PH_PCT: begin
				if (!v[4]) begin
					if (in_last) begin
						cmd.data[0] = CH_PERCENT;
						cmd.data[1] = in_byte;
						n = 2'd2;
					end else begin
						held_d  = in_byte;
						phase_d = PH_DIGIT;
					end
				end else begin
					cmd.data[0] = CH_PERCENT;
					n = 2'd1;
					do_plain = 1'b1;
				end
			end
			PH_DIGIT: begin
				if (!v[4]) begin
					cmd.data[0] = {hv[3:0], v[3:0]};
					n = 2'd1;
				end else begin
					cmd.data[0] = CH_PERCENT;
					cmd.data[1] = held_q;
					n = 2'd2;
					do_plain = 1'b1;
				end
			end
			default: do_plain = 1'b1;
		endcase
		if (do_plain) begin
			if (in_byte == CH_PERCENT) begin
				if (in_last) begin
					cmd.data[n] = CH_PERCENT;
					n = n + 2'd1;
				end else begin
					phase_d = PH_PCT;
				end
			end else begin
				cmd.data[n] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
				n = n + 2'd1;
			end
		end
		cmd.cnt  = n;
		cmd.last = in_last;
	end

	assign push = accept && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			held_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

// ===== sv/upd_queue.sv =====
`timescale 1ns / 1ps

module upd_queue import upd_pkg::*; #(
	parameter int DEPTH = UPD_QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    wdata,
	input  logic    pop,
	output cmd_t    rdata,
	output q_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.empty = (count_q == CW'(0));
	assign stat.full  = (count_q == CW'(DEPTH));
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// ===== sv/upd_back.sv =====
`timescale 1ns / 1ps

module upd_back import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       head_valid,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       load;
	logic       final_byte;

	assign load       = head_valid && (!valid_q || out_ready);
	assign final_byte = (idx_q == head.cnt - 2'd1);
	assign pop        = load && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= final_byte ? 2'd0 : idx_q + 2'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.data[idx_q];
			last_q <= head.last && final_byte;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

endmodule

// ===== sv/url_percent_decoder.sv =====
// Streaming percent decoder for URL / form-urlencoded text. One encoded byte
// is taken per cycle; each request yields zero to three decoded bytes, which
// go into a QUEUE_DEPTH-entry command queue and leave, one byte per cycle
// while out_ready is high, through a registered output; each byte passes
// through the queue memory, then the output register. The output register
// sets the sustained rate of one byte per cycle; the input stalls only when
// the queue fills, either because out_ready is held low or because bursts
// from bad or cut escapes outrun the output. A '%' with two hex digits
// becomes the encoded byte, a plain '+' becomes a space, and a broken escape
// passes through literally. out_last marks the final byte of each string.
`timescale 1ns / 1ps

module url_percent_decoder import upd_pkg::*; #(
	parameter int QUEUE_DEPTH = UPD_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	`include "assert_macros.svh"

	cmd_t    cmd;
	cmd_t    head;
	logic    q_push;
	logic    q_pop;
	q_stat_t q_stat;
	logic    accept;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	upd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.in_last (in_last),
		.push    (q_push),
		.cmd     (cmd)
	);

	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (cmd),
		.pop    (q_pop),
		.rdata  (head),
		.stat   (q_stat)
	);

	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_stat.empty),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

	`UPD_ASSERT(a_push_not_full, q_push |-> !q_stat.full, "push into full queue")
	`UPD_ASSERT(a_pop_not_empty, q_pop |-> !q_stat.empty, "pop from empty queue")
	`UPD_ASSERT(a_push_has_bytes, q_push |-> (cmd.cnt != 2'd0), "empty command queued")
	`UPD_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "output valid in reset")

endmodule
